### rtl/core/hse_pkg.sv
// hse_pkg: shared types, constants and helpers of the heap sort engine
// used by hse_ctrl and heap_sort_engine_top; no dependencies
`default_nettype none

package hse_pkg;

  localparam int HSE_MAX_ELEMENTS = 64;
  localparam int HSE_DATA_W       = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_CMP,
    ST_UP_FIN,
    ST_DN_A,
    ST_DN_B,
    ST_DN_C,
    ST_DN_SIFT,
    ST_DN_L,
    ST_DN_R,
    ST_EMIT_RD,
    ST_EMIT_LD
  } hse_state_t;

  // result load request from the sequencer to the output register
  typedef struct packed {
    logic load;
    logic last;
    logic trunc;
  } hse_emit_t;

  // signed greater-than on raw data words
  function automatic logic hse_gt(input logic [HSE_DATA_W-1:0] a,
                                  input logic [HSE_DATA_W-1:0] b);
    hse_gt = $signed(a) > $signed(b);
  endfunction

endpackage

`default_nettype wire

### rtl/core/heap_sort_engine_top.sv
// heap_sort_engine_top: heap sort engine with stream input and output channels
// depends on hse_pkg, hse_ctrl and hse_ram
//
// usage: values enter one request at a time on in_*; in_tlast closes the set.
// up to MAX_ELEMENTS values are kept, further ones are dropped and every
// result of that run then carries out_tuser = 1.
// after the closing request the set is sorted in the heap ram and replayed on
// out_* in ascending order, out_tlast on the largest value.
// the first value of a set is written straight to the root; each later one that
// is kept climbs the heap one level at a time, and in_tready is low meanwhile.
// sorting moves the root to the tail through ST_DN_A, ST_DN_B and ST_DN_C,
// then sifts the tail value down through ST_DN_SIFT, ST_DN_L and ST_DN_R,
// paced by the single ram read port; readout reads one result (ST_EMIT_RD)
// and loads it into the output register (ST_EMIT_LD) before the next is read.
// in_tready is high only while no set is being sorted or replayed; the next set
// may be accepted while the last result still waits in the output register.
// a stalled receiver holds the output register and pauses the readout.
// reset (rst_n low, synchronous) empties the store and the output register.
`default_nettype none

module heap_sort_engine_top import hse_pkg::*; #(
  parameter int MAX_ELEMENTS = HSE_MAX_ELEMENTS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] value
  input  wire logic        in_tlast,   // end_of_set
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,  // [31:0] sorted_value
  output logic             out_tlast,  // end_of_run
  output logic             out_tuser   // [0] truncated
);

  localparam int AW = $clog2(MAX_ELEMENTS);

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [HSE_DATA_W-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [HSE_DATA_W-1:0] ram_rdata;
  hse_emit_t             emit;
  logic                  out_free;

  logic                  out_valid_r, out_valid_nxt;
  logic [HSE_DATA_W-1:0] out_data_r;
  logic                  out_last_r;
  logic                  out_trunc_r;

  hse_ram #(
    .WIDTH (HSE_DATA_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_heap_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hse_ctrl #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_value  (in_tdata),
    .in_last   (in_tlast),
    .out_free  (out_free),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .emit      (emit)
  );

  // output register frees up when empty or taken this cycle
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      out_data_r  <= ram_rdata;
      out_last_r  <= emit.last;
      out_trunc_r <= emit.trunc;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_trunc_r;

`ifndef SYNTHESIS
  a_load_into_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit.load |-> !out_valid_r)
    else $error("result loaded over a pending result");

  a_no_input_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    emit.load |-> !in_tready)
    else $error("input accepted during readout");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable({out_tdata, out_tlast, out_tuser}))
    else $error("pending result changed before it was taken");
`endif

endmodule

`default_nettype wire

### rtl/core/hse_ram.sv
// hse_ram: generic single-clock ram, one write port and one read port
// read data is registered; no dependencies
`default_nettype none

module hse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/hse_ctrl.sv
// hse_ctrl: heap sequencer; sift-up on insert, root extraction with sift-down,
// then in-order readout. depends on hse_pkg, drives one hse_ram
`default_nettype none

module hse_ctrl import hse_pkg::*; #(
  parameter int MAX_ELEMENTS = HSE_MAX_ELEMENTS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [HSE_DATA_W-1:0]             in_value,
  input  wire logic                              in_last,
  input  wire logic                              out_free,
  output logic                                   ram_we,
  output logic      [$clog2(MAX_ELEMENTS)-1:0]   ram_waddr,
  output logic      [HSE_DATA_W-1:0]             ram_wdata,
  output logic      [$clog2(MAX_ELEMENTS)-1:0]   ram_raddr,
  input  wire logic [HSE_DATA_W-1:0]             ram_rdata,
  output hse_emit_t                              emit
);

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int IW = $clog2(MAX_ELEMENTS + 1);
  localparam int CW = IW + 1;

  hse_state_t            state_r, state_nxt;
  logic [IW-1:0]         count_r, count_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  last_r, last_nxt;
  logic [HSE_DATA_W-1:0] cur_r, cur_nxt;
  logic [HSE_DATA_W-1:0] lchild_r, lchild_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic [IW-1:0]         end_r, end_nxt;
  logic [AW-1:0]         k_r, k_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      ovf_r   <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    lchild_r <= lchild_nxt;
    idx_r    <= idx_nxt;
    end_r    <= end_nxt;
    k_r      <= k_nxt;
  end

  always_comb begin
    logic [IW-1:0]         new_idx;
    logic [IW-1:0]         half_idx;
    logic [CW-1:0]         lc_idx;
    logic [CW-1:0]         rc_idx;
    logic [CW-1:0]         end_ext;
    logic [HSE_DATA_W-1:0] big_val;
    logic [CW-1:0]         big_idx;
    logic                  start_sort;
    logic                  next_end;
    logic [IW-1:0]         sort_n;

    state_nxt  = state_r;
    count_nxt  = count_r;
    ovf_nxt    = ovf_r;
    last_nxt   = last_r;
    cur_nxt    = cur_r;
    lchild_nxt = lchild_r;
    idx_nxt    = idx_r;
    end_nxt    = end_r;
    k_nxt      = k_r;
    in_ready   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_raddr  = '0;
    emit       = '0;
    start_sort = 1'b0;
    next_end   = 1'b0;
    sort_n     = count_r;

    new_idx  = count_r + 1'b1;
    half_idx = idx_r >> 1;
    lc_idx   = {idx_r, 1'b0};
    rc_idx   = {idx_r, 1'b1};
    end_ext  = {1'b0, end_r};
    big_val  = lchild_r;
    big_idx  = lc_idx;
    if (hse_gt(ram_rdata, lchild_r)) begin
      big_val = ram_rdata;
      big_idx = rc_idx;
    end

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          last_nxt = in_last;
          if (count_r < IW'(MAX_ELEMENTS)) begin
            count_nxt = new_idx;
            cur_nxt   = in_value;
            idx_nxt   = new_idx;
            sort_n    = new_idx;
            if (count_r == '0) begin
              ram_we     = 1'b1;
              ram_waddr  = '0;
              ram_wdata  = in_value;
              start_sort = in_last;
            end else begin
              ram_raddr = AW'((new_idx >> 1) - 1'b1);
              state_nxt = ST_UP_CMP;
            end
          end else begin
            ovf_nxt    = 1'b1;
            start_sort = in_last;
          end
        end
      end
      ST_UP_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(idx_r - 1'b1);
        if (hse_gt(cur_r, ram_rdata)) begin
          // parent moves down into the hole
          ram_wdata = ram_rdata;
          idx_nxt   = half_idx;
          if (half_idx == IW'(1)) begin
            state_nxt = ST_UP_FIN;
          end else begin
            ram_raddr = AW'((half_idx >> 1) - 1'b1);
          end
        end else begin
          ram_wdata  = cur_r;
          state_nxt  = ST_IDLE;
          start_sort = last_r;
        end
      end
      ST_UP_FIN: begin
        ram_we     = 1'b1;
        ram_waddr  = '0;
        ram_wdata  = cur_r;
        state_nxt  = ST_IDLE;
        start_sort = last_r;
      end
      ST_DN_A: begin
        ram_raddr = AW'(end_r - 1'b1);
        state_nxt = ST_DN_B;
      end
      ST_DN_B: begin
        cur_nxt   = ram_rdata;
        ram_raddr = '0;
        state_nxt = ST_DN_C;
      end
      ST_DN_C: begin
        // old root goes to the tail slot, tail value sifts down from the root
        ram_we    = 1'b1;
        ram_waddr = AW'(end_r - 1'b1);
        ram_wdata = ram_rdata;
        idx_nxt   = IW'(1);
        state_nxt = ST_DN_SIFT;
      end
      ST_DN_SIFT: begin
        if (lc_idx < end_ext) begin
          ram_raddr = AW'(lc_idx - 1'b1);
          state_nxt = ST_DN_L;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = AW'(idx_r - 1'b1);
          ram_wdata = cur_r;
          next_end  = 1'b1;
        end
      end
      ST_DN_L: begin
        lchild_nxt = ram_rdata;
        if (rc_idx < end_ext) begin
          ram_raddr = AW'(rc_idx - 1'b1);
          state_nxt = ST_DN_R;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = AW'(idx_r - 1'b1);
          if (hse_gt(ram_rdata, cur_r)) begin
            ram_wdata = ram_rdata;
            idx_nxt   = IW'(lc_idx);
            state_nxt = ST_DN_SIFT;
          end else begin
            ram_wdata = cur_r;
            next_end  = 1'b1;
          end
        end
      end
      ST_DN_R: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(idx_r - 1'b1);
        if (hse_gt(big_val, cur_r)) begin
          ram_wdata = big_val;
          idx_nxt   = IW'(big_idx);
          state_nxt = ST_DN_SIFT;
        end else begin
          ram_wdata = cur_r;
          next_end  = 1'b1;
        end
      end
      ST_EMIT_RD: begin
        if (out_free) begin
          ram_raddr = k_r;
          state_nxt = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD: begin
        emit.load  = 1'b1;
        emit.last  = (k_r == AW'(count_r - 1'b1));
        emit.trunc = ovf_r;
        if (emit.last) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_EMIT_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (start_sort) begin
      k_nxt = '0;
      if (sort_n >= IW'(2)) begin
        end_nxt   = sort_n;
        state_nxt = ST_DN_A;
      end else begin
        state_nxt = ST_EMIT_RD;
      end
    end

    if (next_end) begin
      end_nxt = end_r - 1'b1;
      k_nxt   = '0;
      if (end_r == IW'(2)) begin
        state_nxt = ST_EMIT_RD;
      end else begin
        state_nxt = ST_DN_A;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= IW'(MAX_ELEMENTS))
    else $error("element count above capacity");

  a_load_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    emit.load |-> $past(state_r) == ST_EMIT_RD)
    else $error("result load without a preceding readout");

  a_run_clears: assert property (@(posedge clk) disable iff (!rst_n)
    emit.load && emit.last |=> count_r == '0 && !ovf_r && state_r == ST_IDLE)
    else $error("set state not cleared after final result");

  a_sift_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DN_SIFT || state_r == ST_DN_L || state_r == ST_DN_R)
      |-> idx_r < end_r && idx_r != '0)
    else $error("sift-down index outside the active heap");
`endif

endmodule

`default_nettype wire
